>>> hw/rtl/dctw_pkg.sv
package dctw_pkg;

    localparam int CNT_W     = 64;
    localparam int RTC_W     = 32;
    localparam int DIV_W     = 20;
    localparam int REM_W     = DIV_W + 1;
    localparam int PROD_W    = RTC_W + DIV_W;
    localparam int PERIOD_W  = 16;
    localparam int CFG_IDX_W = 1;
    localparam int STEPS     = CNT_W / 2;
    localparam int STEP_W    = $clog2(STEPS);

    localparam logic [DIV_W-1:0] RELOAD_PERIOD = DIV_W'(900000);
    localparam logic [DIV_W-1:0] US_PER_SECOND = DIV_W'(1000000);
    localparam logic [CNT_W-1:0] US_PER_TICK   = CNT_W'(1000);
    localparam logic [CNT_W-1:0] STALL_LIMIT   = CNT_W'(20480);

    localparam logic [PERIOD_W-1:0] SWITCH_PERIOD_RST = PERIOD_W'(10);

    localparam logic [1:0] KIND_MAIN   = 2'd0;
    localparam logic [1:0] KIND_SECOND = 2'd1;

    localparam logic [CFG_IDX_W-1:0] REG_SWITCH_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRECISE       = 1'd1;

    typedef struct packed {
        logic             done;
        logic [REM_W-1:0] rem;
    } mod_status_t;

    typedef enum logic [3:0] {
        S_IDLE       = 4'b0001,
        S_MOD_RELOAD = 4'b0010,
        S_MOD_SWITCH = 4'b0100,
        S_FINISH     = 4'b1000
    } state_t;

endpackage

>>> hw/rtl/dual_core_tick_watchdog_top.sv
// Core 0 transactions pass through the remainder unit; other kinds go straight to the result register.
// One transaction at a time: the next is taken once the result is registered.
// Core 0 work: two passes of the shared 2-bit-per-cycle remainder unit.
// The result register lets a new transaction in while the previous result waits.
// Reset (rst_n, async low) clears counts, epoch, watchdog, precise mode and sets switch_period to 10.
module dual_core_tick_watchdog_top
    import dctw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           kind,
    input  logic [RTC_W-1:0]     rtc_seconds,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [CNT_W-1:0]     main_ticks,
    output logic [CNT_W-1:0]     second_ticks,
    output logic [CNT_W-1:0]     epoch_us,
    output logic                 epoch_reloaded,
    output logic                 task_switch,
    output logic                 send_nmi,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PERIOD_W-1:0]  cfg_data
);

    state_t              state_reg;
    state_t              state_next;
    logic [PERIOD_W-1:0] switch_period_reg;
    logic                precise_reg;
    logic [CNT_W-1:0]    main_reg;
    logic [CNT_W-1:0]    second_reg;
    logic [CNT_W-1:0]    last_seen_reg;
    logic                nmi_sent_reg;
    logic [CNT_W-1:0]    epoch_reg;
    logic [1:0]          kind_reg;
    logic [RTC_W-1:0]    rtc_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic                nmi_flag_reg;
    logic                rel_zero_reg;
    logic                sw_zero_reg;
    logic                start_reg;
    logic                out_valid_reg;
    logic [CNT_W-1:0]    main_out_reg;
    logic [CNT_W-1:0]    second_out_reg;
    logic [CNT_W-1:0]    epoch_out_reg;
    logic                reloaded_out_reg;
    logic                switch_out_reg;
    logic                nmi_out_reg;

    logic                in_fire;
    logic                out_free;
    logic                finish_fire;
    logic [CNT_W-1:0]    main_new;
    logic [CNT_W-1:0]    second_new;
    logic                wd_advanced;
    logic                wd_trip;
    logic                reload;
    logic                do_switch;
    logic [CNT_W-1:0]    epoch_new;
    logic [DIV_W-1:0]    divisor;
    mod_status_t         mod_st;

    assign in_ready    = (state_reg == S_IDLE);
    assign in_fire     = in_valid && in_ready;
    assign out_free    = !out_valid_reg || out_ready;
    assign finish_fire = (state_reg == S_FINISH) && out_free;
    assign cfg_ready   = 1'b1;

    assign main_new    = ((main_reg < second_reg) ? second_reg : main_reg) + 1'b1;
    assign second_new  = ((second_reg == '0) ? main_reg : second_reg) + 1'b1;
    assign wd_advanced = main_reg > last_seen_reg;
    assign wd_trip     = !wd_advanced && !nmi_sent_reg
                         && (second_new > last_seen_reg + STALL_LIMIT);

    assign divisor = (state_reg == S_MOD_SWITCH) ? DIV_W'(switch_period_reg) : RELOAD_PERIOD;

    dctw_mod_unit u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .dividend (main_reg),
        .divisor  (divisor),
        .status   (mod_st)
    );

    always_comb
    begin
        reload    = (epoch_reg == '0) || rel_zero_reg;
        do_switch = (switch_period_reg != '0) && sw_zero_reg;
        if (reload)
        begin
            epoch_new = CNT_W'(prod_reg);
        end
        else if (!precise_reg)
        begin
            epoch_new = epoch_reg + US_PER_TICK;
        end
        else
        begin
            epoch_new = epoch_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (kind == KIND_MAIN) ? S_MOD_RELOAD : S_FINISH;
                end
            end
            S_MOD_RELOAD:
            begin
                if (mod_st.done)
                begin
                    state_next = S_MOD_SWITCH;
                end
            end
            S_MOD_SWITCH:
            begin
                if (mod_st.done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            switch_period_reg <= SWITCH_PERIOD_RST;
            precise_reg       <= 1'b0;
            main_reg          <= '0;
            second_reg        <= '0;
            last_seen_reg     <= '0;
            nmi_sent_reg      <= 1'b0;
            epoch_reg         <= '0;
            start_reg         <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= (in_fire && (kind == KIND_MAIN))
                         || ((state_reg == S_MOD_RELOAD) && mod_st.done);

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_SWITCH_PERIOD: switch_period_reg <= cfg_data;
                    REG_PRECISE:       precise_reg       <= cfg_data[0];
                    default:           ;
                endcase
            end

            if (in_fire)
            begin
                if (kind == KIND_MAIN)
                begin
                    main_reg <= main_new;
                end
                else if (kind == KIND_SECOND)
                begin
                    second_reg <= second_new;
                    if (wd_advanced)
                    begin
                        last_seen_reg <= main_reg;
                        nmi_sent_reg  <= 1'b0;
                    end
                    else if (wd_trip)
                    begin
                        nmi_sent_reg <= 1'b1;
                    end
                end
            end

            if (finish_fire && (kind_reg == KIND_MAIN))
            begin
                epoch_reg <= epoch_new;
            end

            if (finish_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(rtc_reg) * PROD_W'(US_PER_SECOND);
        if (in_fire)
        begin
            kind_reg     <= kind;
            rtc_reg      <= rtc_seconds;
            nmi_flag_reg <= (kind == KIND_SECOND) && wd_trip;
        end
        if ((state_reg == S_MOD_RELOAD) && mod_st.done)
        begin
            rel_zero_reg <= (mod_st.rem == '0);
        end
        if ((state_reg == S_MOD_SWITCH) && mod_st.done)
        begin
            sw_zero_reg <= (mod_st.rem == '0);
        end
        if (finish_fire)
        begin
            main_out_reg   <= main_reg;
            second_out_reg <= second_reg;
            if (kind_reg == KIND_MAIN)
            begin
                epoch_out_reg    <= epoch_new;
                reloaded_out_reg <= reload;
                switch_out_reg   <= do_switch;
                nmi_out_reg      <= 1'b0;
            end
            else
            begin
                epoch_out_reg    <= epoch_reg;
                reloaded_out_reg <= 1'b0;
                switch_out_reg   <= 1'b0;
                nmi_out_reg      <= nmi_flag_reg;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign main_ticks     = main_out_reg;
    assign second_ticks   = second_out_reg;
    assign epoch_us       = epoch_out_reg;
    assign epoch_reloaded = reloaded_out_reg;
    assign task_switch    = switch_out_reg;
    assign send_nmi       = nmi_out_reg;

endmodule

>>> hw/rtl/dctw_mod_unit.sv
module dctw_mod_unit
    import dctw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [CNT_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output mod_status_t      status
);

    logic [CNT_W-1:0]  quo_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  rem_next;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [REM_W-1:0]  r1;
    logic [REM_W-1:0]  r2;
    logic [REM_W-1:0]  d_ext;

    // restoring remainder, two dividend bits per cycle
    always_comb
    begin
        d_ext = {1'b0, divisor};
        r1 = {rem_reg[REM_W-2:0], quo_reg[CNT_W-1]};
        if (r1 >= d_ext)
        begin
            r1 = r1 - d_ext;
        end
        r2 = {r1[REM_W-2:0], quo_reg[CNT_W-2]};
        if (r2 >= d_ext)
        begin
            r2 = r2 - d_ext;
        end
        rem_next = r2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == STEP_W'(STEPS - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[CNT_W-3:0], 2'b00};
            rem_reg <= rem_next;
        end
    end

    assign status.done = done_reg;
    assign status.rem  = rem_reg;

endmodule

>>> hw/rtl/dctw_checker.sv
module dctw_checker
    import dctw_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [CNT_W-1:0] main_ticks,
    input logic             epoch_reloaded,
    input logic             task_switch,
    input logic             send_nmi
);

    // one transaction in flight: busy right after an input transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while previous transaction in flight");

    // core 0 flags and the watchdog flag never share a result
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(send_nmi && (epoch_reloaded || task_switch)))
        else $error("nmi flagged together with core 0 flags");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(main_ticks))
        else $error("stalled result changed");

endmodule

bind dual_core_tick_watchdog_top dctw_checker u_dctw_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .main_ticks     (main_ticks),
    .epoch_reloaded (epoch_reloaded),
    .task_switch    (task_switch),
    .send_nmi       (send_nmi)
);
